[hdl/kvt_pkg.sv]
package kvt_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int LEN_W  = 4;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // s_tdata: func, key_bytes, key_len, value_bytes, value_len, zero pad
    localparam int IN_RAW_W = FUNC_W + KEY_W + LEN_W + VAL_W + LEN_W;
    localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
    // m_tdata: status, found_value, found_value_len, entry_total, zero pad
    localparam int OUT_RAW_W = STAT_W + VAL_W + LEN_W + CNT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_GET    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_RSVD   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_LEN   = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0] value_len;
        logic [VAL_W-1:0] value;
        logic [LEN_W-1:0] key_len;
        logic [KEY_W-1:0] key;
    } kvt_entry_t;

    localparam int ENTRY_W = $bits(kvt_entry_t);

    // keep the low n bytes of a 64-bit string
    function automatic logic [63:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (LEN_W'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[hdl/kvt_ram.sv]
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/kvt_cmp.sv]
module kvt_cmp (
    input  kvt_pkg::kvt_entry_t          entry,
    input  logic [kvt_pkg::KEY_W-1:0]    probe_key,
    input  logic [kvt_pkg::LEN_W-1:0]    probe_len,
    output logic                         match
);

    import kvt_pkg::*;

    logic len_eq;
    logic key_eq;

    // both sides are already masked to their length
    assign len_eq = (entry.key_len == probe_len);
    assign key_eq = (entry.key == probe_key);
    assign match  = len_eq && key_eq;

endmodule

[hdl/linear_key_value_table.sv]
// Timing: append, full and invalid-length items go from accept to the done state and then
//   to the result register; get and remove on a non-empty table also pass the scan state and,
//   for a remove that leaves a gap, the shift state, paced by the one-read, one-write entry memory.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// Reset (rst_n, asynchronous, active low): table empty, capacity_limit = 16, no result pending.
//   The entry memory is not cleared; only entries below the count are ever read.
module linear_key_value_table (
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration: capacity_limit
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kvt_pkg::CNT_W-1:0]   cfg_data,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    // from bit 0: func[1:0], key_bytes[63:0], key_len[3:0], value_bytes[63:0],
    //             value_len[3:0], zero pad
    input  logic [kvt_pkg::IN_W-1:0]    s_tdata,

    output logic                        m_tvalid,
    input  logic                        m_tready,
    // from bit 0: status[1:0], found_value[63:0], found_value_len[3:0],
    //             entry_total[4:0], zero pad
    output logic [kvt_pkg::OUT_W-1:0]   m_tdata
);

    import kvt_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  klen_reg, klen_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;
    logic [LEN_W-1:0]  res_vlen_reg, res_vlen_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // unpacked input item
    logic [FUNC_W-1:0] in_func;
    logic [KEY_W-1:0]  in_key;
    logic [LEN_W-1:0]  in_klen;
    logic [VAL_W-1:0]  in_val;
    logic [LEN_W-1:0]  in_vlen;
    logic              klen_bad;
    logic              vlen_bad;
    logic              accept;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;

    // entry memory ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    kvt_entry_t        ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    kvt_entry_t        ram_rdata;
    logic              match;

    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_key  = s_tdata[FUNC_W +: KEY_W];
    assign in_klen = s_tdata[FUNC_W + KEY_W +: LEN_W];
    assign in_val  = s_tdata[FUNC_W + KEY_W + LEN_W +: VAL_W];
    assign in_vlen = s_tdata[FUNC_W + KEY_W + LEN_W + VAL_W +: LEN_W];

    assign klen_bad = (in_klen == '0) || (in_klen > LEN_W'(KEY_BYTES));
    assign vlen_bad = (in_vlen == '0) || (in_vlen > LEN_W'(VALUE_BYTES));

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // a register value above the table size acts as the table size
    assign limit  = (cap_reg < CNT_W'(DEPTH)) ? cap_reg : CNT_W'(DEPTH);
    assign idx_p1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_p2 = CNT_W'(idx_reg) + CNT_W'(2);

    assign ram_rdata = kvt_entry_t'(ram_rdata_raw);

    kvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // one key compare, reused for every entry of the scan
    kvt_cmp u_cmp (
        .entry     (ram_rdata),
        .probe_key (key_reg),
        .probe_len (klen_reg),
        .match     (match)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        klen_next       = klen_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_vlen_next   = res_vlen_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_p1[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = in_func;
                    key_next      = in_key & byte_mask(in_klen);
                    klen_next     = in_klen;
                    idx_next      = '0;
                    res_val_next  = '0;
                    res_vlen_next = '0;
                    state_next    = S_DONE;
                    if (in_func == FN_RSVD || klen_bad || (in_func == FN_APPEND && vlen_bad))
                    begin
                        res_status_next = STAT_BAD_LEN;
                    end
                    else if (in_func == FN_APPEND)
                    begin
                        if (count_reg >= limit)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            // store at the end of the table
                            ram_we              = 1'b1;
                            ram_waddr           = count_reg[IDX_W-1:0];
                            ram_wdata.key       = in_key & byte_mask(in_klen);
                            ram_wdata.key_len   = in_klen;
                            ram_wdata.value     = in_val & byte_mask(in_vlen);
                            ram_wdata.value_len = in_vlen;
                            count_next          = count_reg + CNT_W'(1);
                            res_status_next     = STAT_OK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        // start the scan at the first entry
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    res_status_next = STAT_OK;
                    res_val_next    = ram_rdata.value;
                    res_vlen_next   = ram_rdata.value_len;
                    if (func_reg == FN_REMOVE && idx_p1 < count_reg)
                    begin
                        // close the gap: idx_reg becomes the write slot
                        ram_re     = 1'b1;
                        ram_raddr  = idx_p1[IDX_W-1:0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        if (func_reg == FN_REMOVE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_p1[IDX_W-1:0];
                    idx_next  = idx_p1[IDX_W-1:0];
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // move entry idx+1 down into idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_p2 < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_p2[IDX_W-1:0];
                    idx_next  = idx_p1[IDX_W-1:0];
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({count_reg, res_vlen_reg, res_val_reg,
                                            res_status_reg});
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= CNT_W'(16);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        klen_reg       <= klen_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_vlen_reg   <= res_vlen_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // the table never holds more than its size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table size");

    // an item in work blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while busy");

    // outside idle, an item removes at most one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=> (count_reg == $past(count_reg) ||
                                 count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count changed by more than one removal");

    // a result is only launched from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result launched outside done state");
`endif

endmodule
